### src/dll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dll_pkg
// shared types and constants of the linked list engine: command and status
// codes, controller states, field widths and parameter defaults
// ----------------------------------------------------------------------------
package dll_pkg;

  // parameter defaults
  localparam int unsigned DEF_POOL_NODES = 256;
  localparam int unsigned DEF_VALUE_BITS = 32;

  // fixed field widths
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned FOUND_W   = 8;
  localparam int unsigned COUNT_W   = 9;
  // widest stored value, used for zero extension between widths
  localparam int unsigned VAL_EXT_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_RM_FRONT  = 3'd2,
    CMD_RM_REAR   = 3'd3,
    CMD_RM_CUR    = 3'd4,
    CMD_CLEAR     = 3'd5,
    CMD_SEARCH    = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_FREE,
    S_INS_LINK,
    S_INS_NB,
    S_INS_NODE,
    S_RM_P,
    S_RM_A,
    S_RM_B,
    S_RM_FIN,
    S_RM_VAL,
    S_SEARCH,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

### src/dll_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dll_cmd_if
// command channel: valid/ready handshake with command code and value
// ----------------------------------------------------------------------------
interface dll_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [dll_pkg::CMD_W-1:0]           cmd;
  logic signed [dll_pkg::DATA_W-1:0]   value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface
`default_nettype wire

### src/dll_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dll_res_if
// result channel: valid/ready handshake with status, match position, list
// length and cursor report
// ----------------------------------------------------------------------------
interface dll_res_if;
  logic                                valid;
  logic                                ready;
  logic [dll_pkg::STATUS_W-1:0]        status;
  logic [dll_pkg::FOUND_W-1:0]         found_index;
  logic [dll_pkg::COUNT_W-1:0]         entry_count;
  logic                                cursor_valid;
  logic signed [dll_pkg::DATA_W-1:0]   cursor_value;

  modport source (output valid, output status, output found_index, output entry_count,
                  output cursor_valid, output cursor_value, input ready);
  modport sink   (input valid, input status, input found_index, input entry_count,
                  input cursor_valid, input cursor_value, output ready);
endinterface
`default_nettype wire

### src/doubly_linked_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_core
// circular doubly linked list with sentinel, kept in a node pool: a value
// ram and a link ram (next/prev pair) driven by a read-modify-write sequencer
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        payload
//  -------  ---  ---------------  ------------------------------------------
//  in_i     in   valid / ready    cmd[2:0], value[31:0] signed
//  out_o    out  valid / ready    status[1:0], found_index[7:0],
//                                 entry_count[8:0], cursor_valid,
//                                 cursor_value[31:0] signed
//
//  one command at a time; the link ram has one read and one write port, and
//  a neighbor's link is patched by a read then a write
//  clear, refused commands and unused codes go from dispatch straight to the
//  result; insert and remove step through their link reads and writes, and
//  search steps once per node compared
//  reset: list empty, cursor and free list on the sentinel, no ram clearing
//  a stalled result sits in the output register; the next item is taken
//  meanwhile and its result waits in the final step until the register frees
//
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_core #(
  parameter int unsigned POOL_NODES = dll_pkg::DEF_POOL_NODES,
  parameter int unsigned VALUE_BITS = dll_pkg::DEF_VALUE_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dll_cmd_if.sink    in_i,
  dll_res_if.source  out_o
);

  // node codes carry one extra value for the sentinel
  localparam int unsigned IDX_BITS  = $clog2(POOL_NODES + 1);
  localparam int unsigned ADDR_BITS = $clog2(POOL_NODES);
  localparam logic [IDX_BITS-1:0] SENT = IDX_BITS'(POOL_NODES);

  typedef logic [IDX_BITS-1:0] idx_t;
  typedef struct packed {
    idx_t nxt;
    idx_t prv;
  } link_t;

  function automatic logic node_ok(idx_t n);
    return n < SENT;
  endfunction

  function automatic logic [ADDR_BITS-1:0] addr_of(idx_t n);
    return ADDR_BITS'(n);
  endfunction

  // controller and list registers
  dll_pkg::state_e state_q, state_d;
  idx_t first_q, first_d;
  idx_t last_q, last_d;
  idx_t cur_q, cur_d;
  idx_t free_q, free_d;
  idx_t fresh_q, fresh_d;
  idx_t count_q, count_d;

  // per command working registers
  logic [dll_pkg::CMD_W-1:0]   cmd_q, cmd_d;
  logic [VALUE_BITS-1:0]       key_q, key_d;
  logic [VALUE_BITS-1:0]       cur_val_q, cur_val_d;
  idx_t                        n_q, n_d;      // new, removed or walked node
  idx_t                        a_q, a_d;      // predecessor
  idx_t                        b_q, b_d;      // successor
  idx_t                        pos_q, pos_d;  // search position
  dll_pkg::status_e            status_q, status_d;
  logic [dll_pkg::FOUND_W-1:0] found_q, found_d;

  // output register
  logic                        ovalid_q, ovalid_d;
  dll_pkg::status_e            ostatus_q, ostatus_d;
  logic [dll_pkg::FOUND_W-1:0] ofound_q, ofound_d;
  logic [dll_pkg::COUNT_W-1:0] ocount_q, ocount_d;
  logic                        ocv_q, ocv_d;
  logic [dll_pkg::DATA_W-1:0]  oval_q, oval_d;

  // memory ports
  logic                  lwe;
  logic [ADDR_BITS-1:0]  lwaddr, lraddr;
  link_t                 lwdata, lrdata;
  logic                  vwe;
  logic [ADDR_BITS-1:0]  vwaddr, vraddr;
  logic [VALUE_BITS-1:0] vwdata, vrdata;

  logic [dll_pkg::VAL_EXT_W-1:0] in_ext;
  logic [dll_pkg::VAL_EXT_W-1:0] cv_ext;
  logic                          front;
  logic                          out_free;
  idx_t                          nb;
  idx_t                          rm_node;
  idx_t                          rm_cur;

  // input value zero extended, then cut to the stored width
  assign in_ext   = {{(dll_pkg::VAL_EXT_W - dll_pkg::DATA_W){1'b0}}, in_i.value};
  assign cv_ext   = dll_pkg::VAL_EXT_W'(cur_val_q);
  assign front    = (cmd_q == dll_pkg::CMD_INS_FRONT);
  assign out_free = !ovalid_q || out_o.ready;
  // neighbor whose link an insert patches
  assign nb       = front ? b_q : a_q;
  // cursor lands on the predecessor, else on the new first node
  assign rm_cur   = node_ok(a_q) ? a_q : b_q;

  always_comb begin
    case (cmd_q)
      dll_pkg::CMD_RM_FRONT: rm_node = first_q;
      dll_pkg::CMD_RM_REAR:  rm_node = last_q;
      default:               rm_node = cur_q;
    endcase
  end

  dll_ram #(
    .WIDTH (2 * IDX_BITS),
    .DEPTH (POOL_NODES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (lwaddr),
    .wdata_i (lwdata),
    .raddr_i (lraddr),
    .rdata_o (lrdata)
  );

  dll_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (POOL_NODES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vwaddr),
    .wdata_i (vwdata),
    .raddr_i (vraddr),
    .rdata_o (vrdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dll_pkg::S_IDLE: begin
        if (in_i.valid) state_d = dll_pkg::S_DISPATCH;
      end
      dll_pkg::S_DISPATCH: begin
        case (cmd_q)
          dll_pkg::CMD_INS_FRONT, dll_pkg::CMD_INS_REAR: begin
            if (node_ok(free_q)) begin
              state_d = dll_pkg::S_INS_FREE;
            end else if (fresh_q != SENT) begin
              state_d = dll_pkg::S_INS_LINK;
            end else begin
              state_d = dll_pkg::S_DONE;
            end
          end
          dll_pkg::CMD_RM_FRONT, dll_pkg::CMD_RM_REAR, dll_pkg::CMD_RM_CUR: begin
            state_d = node_ok(rm_node) ? dll_pkg::S_RM_P : dll_pkg::S_DONE;
          end
          dll_pkg::CMD_SEARCH: begin
            state_d = node_ok(first_q) ? dll_pkg::S_SEARCH : dll_pkg::S_DONE;
          end
          default: state_d = dll_pkg::S_DONE;
        endcase
      end
      dll_pkg::S_INS_FREE: state_d = dll_pkg::S_INS_LINK;
      dll_pkg::S_INS_LINK: begin
        state_d = node_ok(nb) ? dll_pkg::S_INS_NB : dll_pkg::S_INS_NODE;
      end
      dll_pkg::S_INS_NB:   state_d = dll_pkg::S_INS_NODE;
      dll_pkg::S_INS_NODE: state_d = dll_pkg::S_DONE;
      dll_pkg::S_RM_P: begin
        if (node_ok(lrdata.prv)) begin
          state_d = dll_pkg::S_RM_A;
        end else if (node_ok(lrdata.nxt)) begin
          state_d = dll_pkg::S_RM_B;
        end else begin
          state_d = dll_pkg::S_RM_FIN;
        end
      end
      dll_pkg::S_RM_A: begin
        state_d = node_ok(b_q) ? dll_pkg::S_RM_B : dll_pkg::S_RM_FIN;
      end
      dll_pkg::S_RM_B:   state_d = dll_pkg::S_RM_FIN;
      dll_pkg::S_RM_FIN: state_d = dll_pkg::S_RM_VAL;
      dll_pkg::S_RM_VAL: state_d = dll_pkg::S_DONE;
      dll_pkg::S_SEARCH: begin
        if (vrdata != key_q && node_ok(lrdata.nxt) && (pos_q + 1'b1) < SENT) begin
          state_d = dll_pkg::S_SEARCH;
        end else begin
          state_d = dll_pkg::S_DONE;
        end
      end
      dll_pkg::S_DONE: begin
        if (out_free) state_d = dll_pkg::S_IDLE;
      end
      default: state_d = dll_pkg::S_IDLE;
    endcase
  end

  // datapath, memory controls and result
  always_comb begin
    first_d   = first_q;
    last_d    = last_q;
    cur_d     = cur_q;
    free_d    = free_q;
    fresh_d   = fresh_q;
    count_d   = count_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    cur_val_d = cur_val_q;
    n_d       = n_q;
    a_d       = a_q;
    b_d       = b_q;
    pos_d     = pos_q;
    status_d  = status_q;
    found_d   = found_q;

    ovalid_d  = ovalid_q && !out_o.ready;
    ostatus_d = ostatus_q;
    ofound_d  = ofound_q;
    ocount_d  = ocount_q;
    ocv_d     = ocv_q;
    oval_d    = oval_q;

    lwe    = 1'b0;
    lwaddr = '0;
    lwdata = '0;
    lraddr = '0;
    vwe    = 1'b0;
    vwaddr = '0;
    vwdata = '0;
    vraddr = '0;

    unique case (state_q)
      dll_pkg::S_IDLE: begin
        if (in_i.valid) begin
          cmd_d = in_i.cmd;
          key_d = in_ext[VALUE_BITS-1:0];
        end
      end

      dll_pkg::S_DISPATCH: begin
        status_d = dll_pkg::ST_OK;
        found_d  = '0;
        case (cmd_q)
          dll_pkg::CMD_INS_FRONT, dll_pkg::CMD_INS_REAR: begin
            a_d = front ? SENT : last_q;
            b_d = front ? first_q : SENT;
            if (node_ok(free_q)) begin
              // reuse a released node; its next link is the rest of the free list
              n_d    = free_q;
              lraddr = addr_of(free_q);
            end else if (fresh_q != SENT) begin
              n_d     = fresh_q;
              fresh_d = fresh_q + 1'b1;
            end else begin
              status_d = dll_pkg::ST_FULL;
            end
          end
          dll_pkg::CMD_RM_FRONT, dll_pkg::CMD_RM_REAR, dll_pkg::CMD_RM_CUR: begin
            if (node_ok(rm_node)) begin
              n_d    = rm_node;
              lraddr = addr_of(rm_node);
            end else begin
              status_d = dll_pkg::ST_EMPTY;
            end
          end
          dll_pkg::CMD_CLEAR: begin
            // splice the whole list in front of the free list
            if (node_ok(first_q) && node_ok(last_q)) begin
              lwe    = 1'b1;
              lwaddr = addr_of(last_q);
              lwdata = '{nxt: free_q, prv: SENT};
              free_d = first_q;
            end
            first_d = SENT;
            last_d  = SENT;
            cur_d   = SENT;
            count_d = '0;
          end
          dll_pkg::CMD_SEARCH: begin
            if (node_ok(first_q)) begin
              n_d    = first_q;
              pos_d  = '0;
              lraddr = addr_of(first_q);
              vraddr = addr_of(first_q);
            end else begin
              status_d = dll_pkg::ST_MISS;
            end
          end
          default: ;
        endcase
      end

      dll_pkg::S_INS_FREE: begin
        free_d = lrdata.nxt;
      end

      dll_pkg::S_INS_LINK: begin
        if (node_ok(nb)) lraddr = addr_of(nb);
      end

      dll_pkg::S_INS_NB: begin
        // patch one half of the neighbor link, keep the other
        lwe    = 1'b1;
        lwaddr = addr_of(nb);
        if (front) begin
          lwdata = '{nxt: lrdata.nxt, prv: n_q};
        end else begin
          lwdata = '{nxt: n_q, prv: lrdata.prv};
        end
      end

      dll_pkg::S_INS_NODE: begin
        lwe       = 1'b1;
        lwaddr    = addr_of(n_q);
        lwdata    = '{nxt: b_q, prv: a_q};
        vwe       = 1'b1;
        vwaddr    = addr_of(n_q);
        vwdata    = key_q;
        if (!node_ok(a_q)) first_d = n_q;
        if (!node_ok(b_q)) last_d = n_q;
        cur_d     = n_q;
        cur_val_d = key_q;
        count_d   = count_q + 1'b1;
      end

      dll_pkg::S_RM_P: begin
        a_d = lrdata.prv;
        b_d = lrdata.nxt;
        if (node_ok(lrdata.prv)) begin
          lraddr = addr_of(lrdata.prv);
        end else if (node_ok(lrdata.nxt)) begin
          lraddr = addr_of(lrdata.nxt);
        end
      end

      dll_pkg::S_RM_A: begin
        // predecessor skips the removed node; successor read overlaps
        lwe    = 1'b1;
        lwaddr = addr_of(a_q);
        lwdata = '{nxt: b_q, prv: lrdata.prv};
        if (node_ok(b_q)) lraddr = addr_of(b_q);
      end

      dll_pkg::S_RM_B: begin
        lwe    = 1'b1;
        lwaddr = addr_of(b_q);
        lwdata = '{nxt: lrdata.nxt, prv: a_q};
      end

      dll_pkg::S_RM_FIN: begin
        // removed node goes to the head of the free list
        lwe    = 1'b1;
        lwaddr = addr_of(n_q);
        lwdata = '{nxt: free_q, prv: a_q};
        free_d = n_q;
        if (!node_ok(a_q)) first_d = b_q;
        if (!node_ok(b_q)) last_d = a_q;
        cur_d  = rm_cur;
        vraddr = addr_of(rm_cur);
        if (count_q != '0) count_d = count_q - 1'b1;
      end

      dll_pkg::S_RM_VAL: begin
        cur_val_d = vrdata;
      end

      dll_pkg::S_SEARCH: begin
        if (vrdata == key_q) begin
          cur_d     = n_q;
          cur_val_d = key_q;
          found_d   = dll_pkg::FOUND_W'(pos_q);
          status_d  = dll_pkg::ST_OK;
        end else if (node_ok(lrdata.nxt) && (pos_q + 1'b1) < SENT) begin
          n_d    = lrdata.nxt;
          pos_d  = pos_q + 1'b1;
          lraddr = addr_of(lrdata.nxt);
          vraddr = addr_of(lrdata.nxt);
        end else begin
          status_d = dll_pkg::ST_MISS;
        end
      end

      dll_pkg::S_DONE: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = status_q;
          ofound_d  = found_q;
          ocount_d  = dll_pkg::COUNT_W'(count_q);
          ocv_d     = node_ok(cur_q);
          oval_d    = node_ok(cur_q) ? cv_ext[dll_pkg::DATA_W-1:0] : '0;
        end
      end

      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dll_pkg::S_IDLE;
      first_q  <= SENT;
      last_q   <= SENT;
      cur_q    <= SENT;
      free_q   <= SENT;
      fresh_q  <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      first_q  <= first_d;
      last_q   <= last_d;
      cur_q    <= cur_d;
      free_q   <= free_d;
      fresh_q  <= fresh_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    cur_val_q <= cur_val_d;
    n_q       <= n_d;
    a_q       <= a_d;
    b_q       <= b_d;
    pos_q     <= pos_d;
    status_q  <= status_d;
    found_q   <= found_d;
    ostatus_q <= ostatus_d;
    ofound_q  <= ofound_d;
    ocount_q  <= ocount_d;
    ocv_q     <= ocv_d;
    oval_q    <= oval_d;
  end

  assign in_i.ready         = (state_q == dll_pkg::S_IDLE);
  assign out_o.valid        = ovalid_q;
  assign out_o.status       = ostatus_q;
  assign out_o.found_index  = ofound_q;
  assign out_o.entry_count  = ocount_q;
  assign out_o.cursor_valid = ocv_q;
  assign out_o.cursor_value = oval_q;

endmodule
`default_nettype wire

### src/dll_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dll_ram
// generic simple dual port ram, one write and one read port, registered read
// ----------------------------------------------------------------------------
module dll_ram #(
  parameter int unsigned WIDTH = dll_pkg::DEF_VALUE_BITS,
  parameter int unsigned DEPTH = dll_pkg::DEF_POOL_NODES
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### src/dll_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dll_checker
// port level checks of the linked list engine, bound to the top level
// ----------------------------------------------------------------------------
module dll_checker #(
  parameter int unsigned POOL_NODES = dll_pkg::DEF_POOL_NODES
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                out_valid_i,
  input wire logic                                out_ready_i,
  input wire logic [dll_pkg::STATUS_W-1:0]        status_i,
  input wire logic [dll_pkg::FOUND_W-1:0]         found_index_i,
  input wire logic [dll_pkg::COUNT_W-1:0]         entry_count_i,
  input wire logic                                cursor_valid_i,
  input wire logic signed [dll_pkg::DATA_W-1:0]   cursor_value_i
);

  localparam logic [dll_pkg::COUNT_W-1:0] FULL_COUNT = dll_pkg::COUNT_W'(POOL_NODES);

  // stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(entry_count_i) && $stable(cursor_value_i))
    else $error("result changed while stalled");

  // no cursor means no cursor value
  a_cur_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !cursor_valid_i |-> cursor_value_i == '0)
    else $error("cursor value without cursor");

  // a dropped insert only happens with every node on the list
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == dll_pkg::ST_FULL |-> entry_count_i == FULL_COUNT)
    else $error("pool full reported with free nodes");

  // a refused remove leaves the cursor on the sentinel
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == dll_pkg::ST_EMPTY |-> !cursor_valid_i)
    else $error("nothing to remove while cursor on a node");

  // a match position only comes with a successful command
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_index_i != '0 |-> status_i == dll_pkg::ST_OK && cursor_valid_i)
    else $error("match position without a match");

endmodule

bind doubly_linked_list_engine_core dll_checker #(
  .POOL_NODES (POOL_NODES)
) u_dll_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .found_index_i  (out_o.found_index),
  .entry_count_i  (out_o.entry_count),
  .cursor_valid_i (out_o.cursor_valid),
  .cursor_value_i (out_o.cursor_value)
);
`default_nettype wire
